[hw/rtl/four_level_page_walk_translate_core_macros.svh]
// Assertion macros shared by the page walk RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FOUR_LEVEL_PAGE_WALK_TRANSLATE_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_WALK_TRANSLATE_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FLTW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FLTW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/fltw_pkg.sv]
// Package for the four-level page walker: widths, codes and item structs.
// No dependencies.
package fltw_pkg;

	localparam int unsigned ADDR_W              = 52;
	localparam int unsigned VA_W                = 48;
	localparam int unsigned ENTRY_W             = 64;
	localparam int unsigned IDX_W               = 9;
	localparam int unsigned PHYS_ADDR_BITS_DEF  = 52;

	localparam int unsigned PRESENT_POS = 0;
	localparam int unsigned PS_POS      = 7;   // 0x80 in the entry

	localparam logic REQ_TRANSLATE = 1'b0;
	localparam logic REQ_ENTRY     = 1'b1;

	localparam logic KIND_READ   = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	// level of the awaited entry
	localparam logic [1:0] LVL_L1 = 2'd0;
	localparam logic [1:0] LVL_L2 = 2'd1;
	localparam logic [1:0] LVL_L3 = 2'd2;
	localparam logic [1:0] LVL_L4 = 2'd3;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_L4_ABSENT = 3'd1,
		ST_L3_ABSENT = 3'd2,
		ST_HUGE_PAGE = 3'd3,
		ST_L2_ABSENT = 3'd4,
		ST_L1_ABSENT = 3'd5
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic [VA_W-1:0]    virt_addr;
		logic [ADDR_W-1:0]  root_table;
		logic [ENTRY_W-1:0] entry_data;
	} item_t;

	typedef struct packed {
		logic              out_kind;
		logic [ADDR_W-1:0] read_addr;
		logic [ADDR_W-1:0] phys_addr;
		status_t           status;
		logic              large_page;
	} result_t;

	typedef struct packed {
		logic            busy;
		logic [1:0]      level;
		logic [VA_W-1:0] held_va;
	} walk_state_t;

endpackage

[hw/rtl/fltw_step.sv]
// One walk step: from the registered item and the walk state, the result and next state.
// Depends on fltw_pkg.
module fltw_step #(
	parameter int unsigned PHYS_ADDR_BITS = fltw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  fltw_pkg::item_t       item,
	input  fltw_pkg::walk_state_t state,
	output fltw_pkg::result_t     result,
	output logic                  has_result,
	output fltw_pkg::walk_state_t state_next
);
	import fltw_pkg::*;

	localparam logic [ADDR_W-1:0] PA_MASK  = (ADDR_W'(1) << PHYS_ADDR_BITS) - ADDR_W'(1);
	localparam logic [ADDR_W-1:0] F4K_MASK = PA_MASK & ~ADDR_W'(12'hFFF);
	localparam logic [ADDR_W-1:0] F2M_MASK = PA_MASK & ~ADDR_W'(21'h1FFFFF);

	function automatic logic [IDX_W-1:0] table_idx(logic [VA_W-1:0] va, logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			LVL_L4:  idx = va[47:39];
			LVL_L3:  idx = va[38:30];
			LVL_L2:  idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	logic [ADDR_W-1:0] entry_base;
	logic [ADDR_W-1:0] root_base;
	logic [1:0]        lvl_dec;
	logic              present;
	logic              ps_flag;
	status_t           absent_code;

	// table bases are 4 KiB aligned, so base + idx*8 is a plain bit merge
	assign entry_base = item.entry_data[ADDR_W-1:0] & F4K_MASK;
	assign root_base  = item.root_table & F4K_MASK;
	assign lvl_dec    = state.level - 2'd1;
	assign present    = item.entry_data[PRESENT_POS];
	assign ps_flag    = item.entry_data[PS_POS];

	always_comb begin
		case (state.level)
			LVL_L4:  absent_code = ST_L4_ABSENT;
			LVL_L3:  absent_code = ST_L3_ABSENT;
			LVL_L2:  absent_code = ST_L2_ABSENT;
			default: absent_code = ST_L1_ABSENT;
		endcase
	end

	always_comb begin
		result      = '0;
		result.status = ST_OK;
		has_result  = 1'b1;
		state_next  = state;
		if (item.req_type == REQ_TRANSLATE) begin
			// new walk, abandons any walk in progress
			state_next.busy    = 1'b1;
			state_next.level   = LVL_L4;
			state_next.held_va = item.virt_addr;
			result.out_kind    = KIND_READ;
			result.read_addr   = root_base
				| {{(ADDR_W-IDX_W-3){1'b0}}, table_idx(item.virt_addr, LVL_L4), 3'b000};
		end else if (!state.busy) begin
			has_result = 1'b0;
		end else if (!present) begin
			state_next.busy  = 1'b0;
			state_next.level = LVL_L1;
			result.out_kind  = KIND_RESULT;
			result.status    = absent_code;
		end else if (state.level == LVL_L3 && ps_flag) begin
			state_next.busy  = 1'b0;
			state_next.level = LVL_L1;
			result.out_kind  = KIND_RESULT;
			result.status    = ST_HUGE_PAGE;
		end else if (state.level == LVL_L2 && ps_flag) begin
			state_next.busy   = 1'b0;
			state_next.level  = LVL_L1;
			result.out_kind   = KIND_RESULT;
			result.large_page = 1'b1;
			result.phys_addr  = (item.entry_data[ADDR_W-1:0] & F2M_MASK)
				| {{(ADDR_W-21){1'b0}}, state.held_va[20:0]};
		end else if (state.level == LVL_L1) begin
			state_next.busy  = 1'b0;
			state_next.level = LVL_L1;
			result.out_kind  = KIND_RESULT;
			result.phys_addr = entry_base | {{(ADDR_W-12){1'b0}}, state.held_va[11:0]};
		end else begin
			state_next.level = lvl_dec;
			result.out_kind  = KIND_READ;
			result.read_addr = entry_base
				| {{(ADDR_W-IDX_W-3){1'b0}}, table_idx(state.held_va, lvl_dec), 3'b000};
		end
	end

endmodule

[hw/rtl/four_level_page_walk_translate_core.sv]
// Four-level page walker: an input stage, the walk state, the step logic and a result register.
// Use: a translate request (tuser = 0) carries the virtual address and root table value;
// the core answers with a read request for the level-4 entry. Each returned entry
// (tuser = 1) produces either the read request for the next level or a final result
// (m_tuser = 1) with the physical address or a failure status. A new translate
// request abandons a walk in progress; an entry arriving while no walk is active is
// dropped and produces nothing.
// An accepted request is registered in the input stage and then in the result register.
// Throughput: one request per cycle while the receiver does not stall; the only loop is the
// walk state register, updated by mask and merge logic as each request leaves the input stage.
// When the receiver stalls, the result register holds and the input stage takes one
// more request behind it; then s_tready drops until m_tready returns.
// Reset (arst_n low) empties both stages and leaves the walker idle.
// Depends on fltw_pkg, fltw_step and four_level_page_walk_translate_core_macros.svh.
module four_level_page_walk_translate_core #(
	parameter int unsigned PHYS_ADDR_BITS = fltw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,   // virt_addr[47:0], root_table[99:48], entry_data[163:100]
	input  logic [0:0]   s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // read_addr[51:0], phys_addr[103:52], status[106:104],
	                                // large_page[107]
	output logic [0:0]   m_tuser    // out_kind
);
	import fltw_pkg::*;
	`include "four_level_page_walk_translate_core_macros.svh"

	item_t       item_s1;
	logic        valid_s1;
	walk_state_t walk_q;
	walk_state_t walk_next;
	result_t     res;
	logic        has_res;
	result_t     out_q;
	logic        out_valid_q;
	logic        out_free;
	logic        adv_s1;

	fltw_step #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_step (
		.item      (item_s1),
		.state     (walk_q),
		.result    (res),
		.has_result(has_res),
		.state_next(walk_next)
	);

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!has_res || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			walk_q      <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				walk_q <= walk_next;
			end
			if (adv_s1 && has_res) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type   <= s_tuser[0];
			item_s1.virt_addr  <= s_tdata[47:0];
			item_s1.root_table <= s_tdata[99:48];
			item_s1.entry_data <= s_tdata[163:100];
		end
		if (adv_s1 && has_res) begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_q.out_kind;
	assign m_tdata    = {4'b0000, out_q.large_page, out_q.status, out_q.phys_addr,
		out_q.read_addr};

	`FLTW_ASSERT_SAME(a_idle_level, clk, arst_n, !walk_q.busy, walk_q.level == LVL_L1, "idle walker with nonzero level")
	`FLTW_ASSERT_NEXT(a_final_idles, clk, arst_n, adv_s1 && has_res && res.out_kind == KIND_RESULT, !walk_q.busy, "walker still busy after final result")
	`FLTW_ASSERT_NEXT(a_read_busy, clk, arst_n, adv_s1 && has_res && res.out_kind == KIND_READ, walk_q.busy, "read request issued while walker idle")
	`FLTW_ASSERT_SAME(a_read_clean, clk, arst_n, out_valid_q && out_q.out_kind == KIND_READ, out_q.status == ST_OK && out_q.phys_addr == '0 && !out_q.large_page, "read request carries result fields")

endmodule

[verif/four_level_page_walk_translate_core_test.sv]
// Self-checking testbench for four_level_page_walk_translate_core: drives translate
// requests and returned table entries, predicts each read request or final result.
// Depends on fltw_pkg and the core RTL only.
module four_level_page_walk_translate_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fltw_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 310;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [167:0] s_tdata  = '0;   // virt_addr, root_table, entry_data, zero pad
	logic [0:0]   s_tuser  = '0;   // req_type
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;         // read_addr, phys_addr, status, large_page, zero pad
	logic [0:0]   m_tuser;         // out_kind

	// walker state as predicted from accepted requests
	bit              pw_busy;
	logic [1:0]      pw_level;
	logic [VA_W-1:0] pw_va;

	result_t expected_answers[$];
	result_t want;
	int      mismatches;
	int      answered_items;
	int      idle_pct;
	int      stall_pct;
	bit      long_hold_req;
	int      hold_left;
	int      quiet_cycles;

	four_level_page_walk_translate_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// returns 1 when the item yields an answer; updates the predicted walk state
	function automatic bit walk_predict(input item_t it, output result_t r);
		logic [ADDR_W-1:0] base;
		logic [IDX_W-1:0]  idx;
		r = '0;
		r.status = ST_OK;
		if (it.req_type == REQ_TRANSLATE) begin
			pw_va    = it.virt_addr;
			pw_busy  = 1'b1;
			pw_level = LVL_L4;
			base = {it.root_table[ADDR_W-1:12], 12'h000};
			idx  = IDX_W'(pw_va >> (12 + 9 * pw_level));
			r.out_kind  = KIND_READ;
			r.read_addr = base + {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
			return 1'b1;
		end
		if (!pw_busy)
			return 1'b0;
		base = {it.entry_data[ADDR_W-1:12], 12'h000};
		r.out_kind = KIND_RESULT;
		if (!it.entry_data[PRESENT_POS]) begin
			case (pw_level)
				LVL_L4: r.status = ST_L4_ABSENT;
				LVL_L3: r.status = ST_L3_ABSENT;
				LVL_L2: r.status = ST_L2_ABSENT;
				default: r.status = ST_L1_ABSENT;
			endcase
		end else if (pw_level == LVL_L3 && it.entry_data[PS_POS]) begin
			r.status = ST_HUGE_PAGE;
		end else if (pw_level == LVL_L2 && it.entry_data[PS_POS]) begin
			r.phys_addr  = {it.entry_data[ADDR_W-1:21], pw_va[20:0]};
			r.large_page = 1'b1;
		end else if (pw_level == LVL_L1) begin
			r.phys_addr = {it.entry_data[ADDR_W-1:12], pw_va[11:0]};
		end else begin
			// descend one level
			pw_level = pw_level - 2'd1;
			idx = IDX_W'(pw_va >> (12 + 9 * pw_level));
			r.out_kind  = KIND_READ;
			r.read_addr = base + {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
			return 1'b1;
		end
		pw_busy  = 1'b0;
		pw_level = LVL_L1;
		return 1'b1;
	endfunction

	function automatic item_t mk_item(input logic kind, input logic [VA_W-1:0] va,
			input logic [ADDR_W-1:0] root, input logic [ENTRY_W-1:0] entry);
		item_t it;
		it.req_type   = kind;
		it.virt_addr  = va;
		it.root_table = root;
		it.entry_data = entry;
		return it;
	endfunction

	function automatic item_t random_item(input logic kind);
		logic [191:0] bits;
		item_t it;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = item_t'(bits[$bits(item_t)-1:0]);
		it.req_type = kind;
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	// sends one request; valid stays high across back-to-back requests
	task automatic send_item(input item_t it);
		result_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, it.entry_data, it.root_table, it.virt_addr};
		s_tuser  <= it.req_type;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (walk_predict(it, r)) begin
			expected_answers.push_back(r);
			answered_items++;
		end
	endtask

	// sender pauses until every expected answer has come back
	task automatic drain_walker();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (expected_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_walk(input bit broken);
		item_t it;
		int steps;
		send_item(random_item(REQ_TRANSLATE));
		steps = broken ? $urandom_range(0, 2) : 4;
		while (pw_busy && steps > 0) begin
			it = random_item(REQ_ENTRY);
			it.entry_data[PRESENT_POS] = ($urandom_range(99) >= 6);
			it.entry_data[PS_POS]      = ($urandom_range(99) < 30);
			send_item(it);
			steps--;
		end
	endtask

	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		// entry with no walk active is dropped
		send_item(mk_item(REQ_ENTRY, '1, '1, '1));
		send_item(mk_item(REQ_TRANSLATE, '0, '0, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h0));
		// all-ones walk down to a 4 KiB page; page-size bit ignored at L4 and L1
		send_item(mk_item(REQ_TRANSLATE, '1, '1, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, '1));
		send_item(mk_item(REQ_ENTRY, '0, '0, ~64'h80));
		send_item(mk_item(REQ_ENTRY, '0, '0, ~64'h80));
		send_item(mk_item(REQ_ENTRY, '0, '0, '1));
		// new request abandons a walk, then L3 absent
		send_item(mk_item(REQ_TRANSLATE, 48'h8040_2010_0800, 52'h1_2345_6789_A000, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h0000_000F_0000_1001));
		send_item(mk_item(REQ_TRANSLATE, 48'h7FBF_DFEF_F7FF, 52'hF_EDCB_A987_6FFF, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, ~64'h1));
		// 1 GiB page
		send_item(mk_item(REQ_TRANSLATE, 48'hA5A5_5A5A_A5A5, 52'h5_5555_5555_5000, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h0000_0000_ABCD_E001));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'hFFF0_0000_0000_0081));
		// 2 MiB page
		send_item(mk_item(REQ_TRANSLATE, 48'h1234_5678_9ABC, 52'hA_AAAA_AAAA_A123, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, '1));
		// L2 absent
		send_item(mk_item(REQ_TRANSLATE, 48'hFFFF_0000_FFFF, 52'h0_0000_0000_1000, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7E));
		// L1 absent
		send_item(mk_item(REQ_TRANSLATE, 48'h0000_FFFF_0000, '1, '0));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h1));
		send_item(mk_item(REQ_ENTRY, '0, '0, 64'h0));
		drain_walker();
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		long_hold_req = 1'b1;
		repeat (8) run_walk(1'b0);
		drain_walker();
	endtask

	task automatic test_random(input int send_idle, input int recv_stall);
		int target;
		int pick;
		idle_pct  = send_idle;
		stall_pct = recv_stall;
		target = answered_items + PHASE_ITEMS;
		while (answered_items < target) begin
			pick = $urandom_range(99);
			if (pick < 80)
				run_walk(1'b0);
			else if (pick < 90)
				run_walk(1'b1);
			else
				send_item(random_item(1'($urandom_range(1))));
		end
		drain_walker();
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected answer, expected none, got %h / %h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_answers.pop_front();
				check_field("out_kind", 64'(want.out_kind), 64'(m_tuser[0]));
				check_field("read_addr", 64'(want.read_addr), 64'(m_tdata[51:0]));
				check_field("phys_addr", 64'(want.phys_addr), 64'(m_tdata[103:52]));
				check_field("status", 64'(want.status), 64'(m_tdata[106:104]));
				check_field("large_page", 64'(want.large_page), 64'(m_tdata[107]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(0, 0);
		test_random(49, 0);
		test_random(0, 49);
		test_random(34, 34);
		drain_walker();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
